// File: rtl/gcp_pkg.sv
package gcp_pkg;

  localparam int NUM_VALUES  = 16;
  localparam int VAL_W       = 4;
  localparam int MAX_CELLS   = 4096;
  localparam int CELL_W      = 12;
  localparam int QCNT_W      = 13;
  localparam int TRAIL_DEPTH = 65536;
  localparam int TR_AW       = 16;
  localparam int TCNT_W      = 17;
  localparam int DIM_W       = 5;
  localparam int DIM_MAX     = 16;
  localparam int RULE_DEPTH  = 48;
  localparam int RULE_AW     = 6;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_SET      = 3'd1;
  localparam logic [2:0] OP_RESTRICT = 3'd2;
  localparam logic [2:0] OP_SEED     = 3'd3;
  localparam logic [2:0] OP_SETTLE   = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;
  localparam logic [2:0] OP_REWIND   = 3'd6;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Z    = 2'd1;
  localparam logic [1:0] AX_Y    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CONTRA = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DEPTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [2:0]            operation;
    logic [1:0]            axis;
    logic [VAL_W-1:0]      lower_value;
    logic [NUM_VALUES-1:0] value_mask;
    logic [CELL_W-1:0]     cell_req;
    logic [TCNT_W-1:0]     step;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [NUM_VALUES-1:0] domain_bits;
    logic [TCNT_W-1:0]     trail_length;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [CELL_W-1:0] dividend;
    logic [DIM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] quot;
    logic [DIM_W-1:0]  rem;
  } div_rsp_t;

endpackage

// File: rtl/gcp_div.sv
module gcp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gcp_pkg::div_req_t req,
  output gcp_pkg::div_rsp_t rsp
);
  import gcp_pkg::*;

  localparam int CNT_W = $clog2(CELL_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CELL_W-1:0] q_r, q_nxt;
  logic [DIM_W-1:0]  rem_r, rem_nxt;
  logic [DIM_W-1:0]  dvs_r, dvs_nxt;
  logic [DIM_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, q_r[CELL_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // one quotient bit a cycle, restoring
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIM_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[CELL_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIM_W-1:0];
        q_nxt   = {q_r[CELL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CELL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/grid_constraint_propagator.sv
// Load rule and set domain go straight to the result; seed and read pass one more state
// first; one item at a time. Restrict: one domain bit a cycle through the removal step.
// Settle: per popped cell two coordinate divisions, then per neighbour 16 rule-row reads
// and 16 removal steps; clearing the queue takes a pop and a flag clear per entry.
// Rewind: each trail entry is counted down, read and restored. Inputs stall after a
// configuration write. Reset is synchronous; then a pass clears every queued flag.
module grid_constraint_propagator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gcp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gcp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [gcp_pkg::DIM_W-1:0] cfg_data
);
  import gcp_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_INIT = 5'd1;
  localparam logic [4:0] S_FIN  = 5'd2;
  localparam logic [4:0] S_POP  = 5'd3;
  localparam logic [4:0] S_POP2 = 5'd4;
  localparam logic [4:0] S_MINE = 5'd5;
  localparam logic [4:0] S_DIV1 = 5'd6;
  localparam logic [4:0] S_DIV2 = 5'd7;
  localparam logic [4:0] S_NB   = 5'd8;
  localparam logic [4:0] S_SUP  = 5'd9;
  localparam logic [4:0] S_ODOM = 5'd10;
  localparam logic [4:0] S_RM   = 5'd11;
  localparam logic [4:0] S_WB   = 5'd12;
  localparam logic [4:0] S_PUSH = 5'd13;
  localparam logic [4:0] S_CQ   = 5'd14;
  localparam logic [4:0] S_CQ2  = 5'd15;
  localparam logic [4:0] S_RD   = 5'd16;
  localparam logic [4:0] S_RW   = 5'd17;
  localparam logic [4:0] S_RW2  = 5'd18;
  localparam logic [4:0] S_RW3  = 5'd19;

  localparam logic [2:0] DIR_XP = 3'd0;
  localparam logic [2:0] DIR_XN = 3'd1;
  localparam logic [2:0] DIR_ZP = 3'd2;
  localparam logic [2:0] DIR_ZN = 3'd3;
  localparam logic [2:0] DIR_YP = 3'd4;
  localparam logic [2:0] DIR_YN = 3'd5;

  // memories
  logic [NUM_VALUES-1:0] dom_mem  [MAX_CELLS];
  logic [NUM_VALUES-1:0] rule_mem [RULE_DEPTH];
  logic [CELL_W-1:0]     q_mem    [MAX_CELLS];
  logic                  fl_mem   [MAX_CELLS];
  logic [CELL_W+VAL_W-1:0] tr_mem [TRAIL_DEPTH];

  logic                  dom_we;
  logic [CELL_W-1:0]     dom_wa, dom_ra;
  logic [NUM_VALUES-1:0] dom_wd, dom_rd_r;
  logic                  rule_we;
  logic [RULE_AW-1:0]    rule_wa, rule_ra;
  logic [NUM_VALUES-1:0] rule_wd, rule_rd_r;
  logic                  q_we;
  logic [CELL_W-1:0]     q_wa, q_ra, q_wd, q_rd_r;
  logic                  fl_we, fl_wd, fl_rd_r;
  logic [CELL_W-1:0]     fl_wa, fl_ra;
  logic                  tr_we;
  logic [TR_AW-1:0]      tr_wa, tr_ra;
  logic [CELL_W+VAL_W-1:0] tr_wd, tr_rd_r;

  // control state
  logic [4:0]        state_r, state_nxt;
  logic [TCNT_W-1:0] tc_r, tc_nxt;
  logic [CELL_W-1:0] qhead_r, qhead_nxt;
  logic [QCNT_W-1:0] qcount_r, qcount_nxt;
  logic [DIM_W-1:0]  w_r, d_r, h_r, cfg_val;
  logic [2*DIM_W-1:0] wd_r;
  logic [QCNT_W-1:0] total_r;
  logic [3*DIM_W-1:0] tprod;
  logic [1:0]        cfg_wait_r;
  logic [CELL_W-1:0] clr_idx_r, clr_idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  // working registers
  in_item_t          item_r, item_nxt;
  out_item_t         out_r, out_nxt;
  logic [CELL_W-1:0] c_r, c_nxt, o_r, o_nxt, tcell_r, tcell_nxt;
  logic [NUM_VALUES-1:0] mine_r, mine_nxt, sup_r, sup_nxt, work_r, work_nxt;
  logic [NUM_VALUES-1:0] bits_r, bits_nxt;
  logic [VAL_W-1:0]  x_r, x_nxt, z_r, z_nxt, y_r, y_nxt, rv_r, rv_nxt, tval_r, tval_nxt;
  logic [2:0]        dir_r, dir_nxt;
  logic [1:0]        ax_r, ax_nxt, status_r, status_nxt;
  logic              low_r, low_nxt, thin_r, thin_nxt, fail_r, fail_nxt;
  logic              settle_r, settle_nxt;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              nb_ok, nb_low, in_grid;
  logic [QCNT_W-1:0] nb_sum, c13;
  logic [1:0]        nb_ax;

  gcp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE) || (cfg_wait_r != 2'd0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_grid   = {1'b0, in_data.cell_req} < total_r;
  assign tprod     = wd_r * h_r;

  always_comb begin
    cfg_val = cfg_data;
    if (cfg_data == '0) cfg_val = DIM_W'(1);
    else if (cfg_data > DIM_W'(DIM_MAX)) cfg_val = DIM_W'(DIM_MAX);
  end

  // neighbour of the popped cell in the current direction
  always_comb begin
    c13    = {1'b0, c_r};
    nb_ok  = 1'b0;
    nb_sum = c13;
    nb_ax  = AX_X;
    nb_low = 1'b0;
    case (dir_r)
      DIR_XP: begin
        nb_ok = ({1'b0, x_r} + 1'b1) < w_r; nb_sum = c13 + 1'b1; nb_low = 1'b1;
      end
      DIR_XN: begin
        nb_ok = x_r != '0; nb_sum = c13 - 1'b1;
      end
      DIR_ZP: begin
        nb_ok = ({1'b0, z_r} + 1'b1) < d_r; nb_sum = c13 + QCNT_W'(w_r);
        nb_ax = AX_Z; nb_low = 1'b1;
      end
      DIR_ZN: begin
        nb_ok = z_r != '0; nb_sum = c13 - QCNT_W'(w_r); nb_ax = AX_Z;
      end
      DIR_YP: begin
        nb_ok = ({1'b0, y_r} + 1'b1) < h_r; nb_sum = c13 + QCNT_W'(wd_r);
        nb_ax = AX_Y; nb_low = 1'b1;
      end
      DIR_YN: begin
        nb_ok = y_r != '0; nb_sum = c13 - QCNT_W'(wd_r); nb_ax = AX_Y;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    tc_nxt        = tc_r;
    qhead_nxt     = qhead_r;
    qcount_nxt    = qcount_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    item_nxt      = item_r;
    c_nxt = c_r; o_nxt = o_r; tcell_nxt = tcell_r;
    mine_nxt = mine_r; sup_nxt = sup_r; work_nxt = work_r; bits_nxt = bits_r;
    x_nxt = x_r; z_nxt = z_r; y_nxt = y_r; rv_nxt = rv_r; tval_nxt = tval_r;
    dir_nxt = dir_r; ax_nxt = ax_r; status_nxt = status_r;
    low_nxt = low_r; thin_nxt = thin_r; fail_nxt = fail_r; settle_nxt = settle_r;

    dom_we = 1'b0; dom_wa = o_r; dom_wd = work_r; dom_ra = o_r;
    rule_we = 1'b0; rule_wa = {in_data.axis, in_data.lower_value};
    rule_wd = in_data.value_mask; rule_ra = {ax_r, rv_r};
    q_we = 1'b0; q_wa = CELL_W'(qhead_r + qcount_r[CELL_W-1:0]); q_wd = o_r; q_ra = qhead_r;
    fl_we = 1'b0; fl_wa = o_r; fl_wd = 1'b0; fl_ra = o_r;
    tr_we = 1'b0; tr_wa = tc_r[TR_AW-1:0]; tr_wd = {o_r, rv_r};
    tr_ra = TR_AW'(tc_r - 1'b1);
    div_req.start    = 1'b0;
    div_req.dividend = c_r;
    div_req.divisor  = w_r;

    case (state_r)
      S_INIT: begin
        fl_we       = 1'b1;
        fl_wa       = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CELL_W'(MAX_CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          item_nxt   = in_data;
          status_nxt = ST_OK;
          bits_nxt   = '0;
          settle_nxt = 1'b0;
          o_nxt      = in_data.cell_req;
          state_nxt  = S_FIN;
          case (in_data.operation)
            OP_LOAD: rule_we = in_data.axis != AX_NONE;
            OP_SET: begin
              dom_we = in_grid;
              dom_wa = in_data.cell_req;
              dom_wd = in_data.value_mask;
            end
            OP_RESTRICT: begin
              if (in_grid) begin
                dom_ra    = in_data.cell_req;
                sup_nxt   = in_data.value_mask;
                state_nxt = S_ODOM;
              end
            end
            OP_SEED: begin
              if (in_grid) begin
                fl_ra     = in_data.cell_req;
                state_nxt = S_PUSH;
              end
            end
            OP_SETTLE: begin
              settle_nxt = 1'b1;
              state_nxt  = S_POP;
            end
            OP_READ: begin
              if (in_grid) begin
                dom_ra    = in_data.cell_req;
                state_nxt = S_RD;
              end
            end
            OP_REWIND: state_nxt = S_RW;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_POP: begin
        if (qcount_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          qhead_nxt  = qhead_r + 1'b1;
          qcount_nxt = qcount_r - 1'b1;
          state_nxt  = S_POP2;
        end
      end
      S_POP2: begin
        c_nxt  = q_rd_r;
        fl_we  = 1'b1;
        fl_wa  = q_rd_r;
        dom_ra = q_rd_r;
        // skip cells that fell outside the grid
        state_nxt = ({1'b0, q_rd_r} >= total_r) ? S_POP : S_MINE;
      end
      S_MINE: begin
        mine_nxt      = dom_rd_r;
        div_req.start = 1'b1;
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          x_nxt            = div_rsp.rem[VAL_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quot;
          div_req.divisor  = d_r;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          z_nxt     = div_rsp.rem[VAL_W-1:0];
          y_nxt     = div_rsp.quot[VAL_W-1:0];
          dir_nxt   = DIR_XP;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (dir_r > DIR_YN) begin
          state_nxt = S_POP;
        end else if (nb_ok && nb_sum < total_r) begin
          o_nxt     = nb_sum[CELL_W-1:0];
          ax_nxt    = nb_ax;
          low_nxt   = nb_low;
          rv_nxt    = '0;
          sup_nxt   = '0;
          rule_ra   = {nb_ax, VAL_W'(0)};
          state_nxt = S_SUP;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      S_SUP: begin
        if (low_r) begin
          if (mine_r[rv_r]) sup_nxt = sup_r | rule_rd_r;
        end else if ((rule_rd_r & mine_r) != '0) begin
          sup_nxt[rv_r] = 1'b1;
        end
        if (rv_r == VAL_W'(NUM_VALUES - 1)) begin
          state_nxt = S_ODOM;
        end else begin
          rule_ra = {ax_r, VAL_W'(rv_r + 1'b1)};
          rv_nxt  = rv_r + 1'b1;
        end
      end
      S_ODOM: begin
        work_nxt  = dom_rd_r;
        rv_nxt    = '0;
        thin_nxt  = 1'b0;
        fail_nxt  = 1'b0;
        state_nxt = S_RM;
      end
      S_RM: begin
        if (work_r[rv_r] && !sup_r[rv_r]) begin
          if (tc_r == TCNT_W'(TRAIL_DEPTH)) begin
            fail_nxt  = 1'b1;
            state_nxt = S_WB;
          end else begin
            tr_we          = 1'b1;
            tc_nxt         = tc_r + 1'b1;
            work_nxt[rv_r] = 1'b0;
            thin_nxt       = 1'b1;
          end
        end
        if (rv_r == VAL_W'(NUM_VALUES - 1)) state_nxt = S_WB;
        else rv_nxt = rv_r + 1'b1;
      end
      S_WB: begin
        dom_we = 1'b1;
        if (!settle_r) begin
          status_nxt = fail_r ? ST_FULL : ST_OK;
          state_nxt  = S_FIN;
        end else if (fail_r) begin
          status_nxt = ST_FULL;
          state_nxt  = S_CQ;
        end else if (work_r == '0) begin
          status_nxt = ST_CONTRA;
          state_nxt  = S_CQ;
        end else if (thin_r) begin
          state_nxt = S_PUSH;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NB;
        end
      end
      S_PUSH: begin
        if (!fl_rd_r && qcount_r < QCNT_W'(MAX_CELLS)) begin
          q_we       = 1'b1;
          fl_we      = 1'b1;
          fl_wd      = 1'b1;
          qcount_nxt = qcount_r + 1'b1;
        end
        if (settle_r) begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NB;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CQ: begin
        // drop the rest of the queue, clearing its flags
        if (qcount_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          qhead_nxt  = qhead_r + 1'b1;
          qcount_nxt = qcount_r - 1'b1;
          state_nxt  = S_CQ2;
        end
      end
      S_CQ2: begin
        fl_we     = 1'b1;
        fl_wa     = q_rd_r;
        state_nxt = S_CQ;
      end
      S_RD: begin
        bits_nxt  = dom_rd_r;
        state_nxt = S_FIN;
      end
      S_RW: begin
        if (tc_r > item_r.step) begin
          tc_nxt    = tc_r - 1'b1;
          state_nxt = S_RW2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RW2: begin
        tcell_nxt = tr_rd_r[CELL_W+VAL_W-1:VAL_W];
        tval_nxt  = tr_rd_r[VAL_W-1:0];
        dom_ra    = tr_rd_r[CELL_W+VAL_W-1:VAL_W];
        state_nxt = S_RW3;
      end
      S_RW3: begin
        dom_we    = 1'b1;
        dom_wa    = tcell_r;
        dom_wd    = dom_rd_r | (NUM_VALUES'(1) << tval_r);
        state_nxt = S_RW;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status       = status_r;
          out_nxt.domain_bits  = bits_r;
          out_nxt.trail_length = tc_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      tc_r        <= '0;
      qhead_r     <= '0;
      qcount_r    <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      w_r         <= DIM_W'(DIM_MAX);
      d_r         <= DIM_W'(DIM_MAX);
      h_r         <= DIM_W'(DIM_MAX);
      cfg_wait_r  <= 2'd2;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      qhead_r     <= qhead_nxt;
      qcount_r    <= qcount_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  w_r <= cfg_val;
          CFG_DEPTH:  d_r <= cfg_val;
          CFG_HEIGHT: h_r <= cfg_val;
          default: ;
        endcase
      end
      // hold inputs until the grid size products catch up
      if (cfg_we) cfg_wait_r <= 2'd2;
      else if (cfg_wait_r != 2'd0) cfg_wait_r <= cfg_wait_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    wd_r     <= w_r * d_r;
    total_r  <= (tprod > (3*DIM_W)'(MAX_CELLS)) ? QCNT_W'(MAX_CELLS) : QCNT_W'(tprod);
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    c_r      <= c_nxt;
    o_r      <= o_nxt;
    tcell_r  <= tcell_nxt;
    mine_r   <= mine_nxt;
    sup_r    <= sup_nxt;
    work_r   <= work_nxt;
    bits_r   <= bits_nxt;
    x_r      <= x_nxt;
    z_r      <= z_nxt;
    y_r      <= y_nxt;
    rv_r     <= rv_nxt;
    tval_r   <= tval_nxt;
    dir_r    <= dir_nxt;
    ax_r     <= ax_nxt;
    status_r <= status_nxt;
    low_r    <= low_nxt;
    thin_r   <= thin_nxt;
    fail_r   <= fail_nxt;
    settle_r <= settle_nxt;
  end

  always_ff @(posedge clk) begin
    if (dom_we) dom_mem[dom_wa] <= dom_wd;
    dom_rd_r <= dom_mem[dom_ra];
  end

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    rule_rd_r <= rule_mem[rule_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_r <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_rd_r <= fl_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_wa] <= tr_wd;
    tr_rd_r <= tr_mem[tr_ra];
  end

endmodule

// File: rtl/gcp_checker.sv
module gcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gcp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gcp_pkg::out_item_t out_data,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [gcp_pkg::DIM_W-1:0] cfg_data
);
  import gcp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_CONTRA ||
                   out_data.status == ST_FULL))
    else $error("reserved status code");

  a_bits_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.domain_bits == '0)
    else $error("domain bits on a failed item");

  a_trail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.trail_length <= TCNT_W'(TRAIL_DEPTH))
    else $error("trail length beyond depth");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken straight after reset");

endmodule

bind grid_constraint_propagator gcp_checker u_gcp_checker (.*);

// File: dv/tb_top.sv
module tb_top;
  import gcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_NOP = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  grid_constraint_propagator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the grid state
  logic [NUM_VALUES-1:0] dom_s [MAX_CELLS];
  logic [NUM_VALUES-1:0] rule_s [RULE_DEPTH];
  logic                  queued_s [MAX_CELLS];
  int unsigned           work_s [$];
  int unsigned           trail_cell [TRAIL_DEPTH];
  int unsigned           trail_val [TRAIL_DEPTH];
  int unsigned           trail_cnt;
  int unsigned           gw, gd, gh;

  out_item_t pending_results [$];
  int        errs;
  int        send_gap_pct;
  int        recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned grid_cells();
    int unsigned n;
    n = gw * gd * gh;
    return (n > MAX_CELLS) ? MAX_CELLS : n;
  endfunction

  function automatic void drop_queue();
    foreach (queued_s[i]) queued_s[i] = 1'b0;
    work_s.delete();
  endfunction

  function automatic void queue_cell(int unsigned c);
    if (queued_s[c] || work_s.size() >= MAX_CELLS) return;
    work_s = {work_s, c};
    queued_s[c] = 1'b1;
  endfunction

  function automatic bit log_removal(int unsigned c, int unsigned v);
    if (trail_cnt >= TRAIL_DEPTH) return 1'b0;
    dom_s[c][v] = 1'b0;
    trail_cell[trail_cnt] = c;
    trail_val[trail_cnt] = v;
    trail_cnt++;
    return 1'b1;
  endfunction

  function automatic logic [1:0] propagate();
    int unsigned c, total, x, z, y, n, o;
    int unsigned nb [6];
    int unsigned ax [6];
    bit          up [6];
    logic [NUM_VALUES-1:0] mine, sup, row;
    bit thinned;
    while (work_s.size() > 0) begin
      c = work_s.pop_front();
      queued_s[c] = 1'b0;
      total = grid_cells();
      if (c >= total) continue;
      x = c % gw;
      z = (c / gw) % gd;
      y = c / (gw * gd);
      n = 0;
      if (x + 1 < gw) begin nb[n] = c + 1; ax[n] = AX_X; up[n] = 1; n++; end
      if (x > 0) begin nb[n] = c - 1; ax[n] = AX_X; up[n] = 0; n++; end
      if (z + 1 < gd) begin nb[n] = c + gw; ax[n] = AX_Z; up[n] = 1; n++; end
      if (z > 0) begin nb[n] = c - gw; ax[n] = AX_Z; up[n] = 0; n++; end
      if (y + 1 < gh) begin nb[n] = c + gw * gd; ax[n] = AX_Y; up[n] = 1; n++; end
      if (y > 0) begin nb[n] = c - gw * gd; ax[n] = AX_Y; up[n] = 0; n++; end
      for (int i = 0; i < n; i++) begin
        o = nb[i];
        if (o >= total) continue;
        mine = dom_s[c];
        sup = '0;
        thinned = 0;
        for (int v = 0; v < NUM_VALUES; v++) begin
          row = rule_s[ax[i] * NUM_VALUES + v];
          if (up[i]) begin
            if (mine[v]) sup |= row;
          end else if ((row & mine) != 0) begin
            sup[v] = 1'b1;
          end
        end
        for (int v = 0; v < NUM_VALUES; v++) begin
          if (dom_s[o][v] && !sup[v]) begin
            if (!log_removal(o, v)) begin
              drop_queue();
              return ST_FULL;
            end
            thinned = 1;
          end
        end
        if (dom_s[o] == 0) begin
          drop_queue();
          return ST_CONTRA;
        end
        if (thinned) queue_cell(o);
      end
    end
    return ST_OK;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    bit        in_grid;
    in_grid = it.cell_req < grid_cells();
    r = '0;
    case (it.operation)
      OP_LOAD: if (it.axis != AX_NONE) rule_s[it.axis * NUM_VALUES + it.lower_value] = it.value_mask;
      OP_SET: if (in_grid) dom_s[it.cell_req] = it.value_mask;
      OP_RESTRICT: if (in_grid) begin
        for (int v = 0; v < NUM_VALUES; v++) begin
          if (dom_s[it.cell_req][v] && !it.value_mask[v]) begin
            if (!log_removal(it.cell_req, v)) begin
              r.status = ST_FULL;
              break;
            end
          end
        end
      end
      OP_SEED: if (in_grid) queue_cell(it.cell_req);
      OP_SETTLE: r.status = propagate();
      OP_READ: if (in_grid) r.domain_bits = dom_s[it.cell_req];
      OP_REWIND: while (trail_cnt > it.step) begin
        trail_cnt--;
        dom_s[trail_cell[trail_cnt]][trail_val[trail_cnt]] = 1'b1;
      end
      default: ;
    endcase
    r.trail_length = TCNT_W'(trail_cnt);
    return r;
  endfunction

  task automatic send_item(in_item_t it);
    out_item_t r;
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    r = apply_item(it);
    pending_results = {pending_results, r};
  endtask

  task automatic send_op(logic [2:0] op, logic [1:0] axis = AX_X, logic [3:0] lv = '0,
                         logic [15:0] mask = '0, logic [11:0] cell_idx = '0,
                         logic [16:0] step = '0);
    in_item_t it;
    it.operation = op;
    it.axis = axis;
    it.lower_value = lv;
    it.value_mask = mask;
    it.cell_req = cell_idx;
    it.step = step;
    send_item(it);
  endtask

  // drain results, then hold the input quiet before touching registers
  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() > 0 && guard < 4_000_000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() > 0) begin
      $display("== FAIL ==");
      $finish;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
    int unsigned v;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    v = (val == 0) ? 1 : ((val > DIM_MAX) ? DIM_MAX : val);
    case (idx)
      CFG_WIDTH:  gw = v;
      CFG_DEPTH:  gd = v;
      CFG_HEIGHT: gh = v;
      default: ;
    endcase
  endtask

  // reshape the grid and give every cell in it a fresh, mostly full domain
  task automatic reshape_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] d, logic [DIM_W-1:0] h);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_DEPTH, d);
    write_reg(CFG_HEIGHT, h);
    for (int c = 0; c < grid_cells(); c++)
      send_op(OP_SET, AX_X, '0, 16'($urandom | $urandom | $urandom), 12'(c));
  endtask

  task automatic test_rule_load();
    for (int a = 0; a < 3; a++)
      for (int v = 0; v < NUM_VALUES; v++)
        send_op(OP_LOAD, 2'(a), 4'(v), 16'($urandom | $urandom | $urandom));
  endtask

  task automatic test_directed();
    reshape_grid(4, 3, 2);
    send_op(OP_LOAD, AX_NONE, 4'hF, 16'hFFFF);
    send_op(OP_NOP, AX_NONE, 4'hF, 16'hFFFF, 12'hFFF, 17'h1FFFF);
    send_op(OP_SET, AX_X, '0, 16'hFFFF, 12'd0);
    send_op(OP_SET, AX_X, '0, 16'h0000, 12'hFFF);
    send_op(OP_READ, AX_X, '0, '0, 12'hFFF);
    send_op(OP_READ, AX_X, '0, '0, 12'd0);
    send_op(OP_RESTRICT, AX_X, '0, 16'h8001, 12'd0);
    send_op(OP_RESTRICT, AX_X, '0, 16'h0000, 12'd23);
    send_op(OP_READ, AX_X, '0, '0, 12'd23);
    send_op(OP_SEED, AX_X, '0, '0, 12'd0);
    send_op(OP_SEED, AX_X, '0, '0, 12'd0);
    send_op(OP_SEED, AX_X, '0, '0, 12'hFFF);
    send_op(OP_SETTLE);
    send_op(OP_REWIND, AX_X, '0, '0, '0, 17'h10000);
    send_op(OP_REWIND, AX_X, '0, '0, '0, 17'd1);
    // empty neighbour ends the settle at once
    send_op(OP_SET, AX_X, '0, 16'h0000, 12'd1);
    send_op(OP_SEED, AX_X, '0, '0, 12'd0);
    send_op(OP_SEED, AX_X, '0, '0, 12'd5);
    send_op(OP_SETTLE);
    send_op(OP_SETTLE);
    send_op(OP_READ, AX_X, '0, '0, 12'd1);
    send_op(OP_REWIND, AX_X, '0, '0, '0, 17'd0);
    send_op(OP_READ, AX_X, '0, '0, 12'd0);
  endtask

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick, total;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    total = grid_cells();
    if ($urandom_range(99) < 85) it.cell_req = 12'($urandom_range(0, total - 1));
    pick = $urandom_range(99);
    if (pick < 5) begin
      it.operation = OP_LOAD;
      if ($urandom_range(9) != 0) it.value_mask = it.value_mask | 16'($urandom);
    end else if (pick < 20) begin
      it.operation = OP_SET;
      if ($urandom_range(9) != 0) it.value_mask = 16'($urandom | $urandom | $urandom);
    end else if (pick < 40) begin
      it.operation = OP_RESTRICT;
      if ($urandom_range(3) != 0)
        it.value_mask = ~(16'(1) << $urandom_range(15)) & ~(16'(1) << $urandom_range(15));
    end else if (pick < 65) begin
      it.operation = OP_SEED;
    end else if (pick < 80) begin
      it.operation = OP_SETTLE;
    end else if (pick < 92) begin
      it.operation = OP_READ;
    end else if (pick < 98) begin
      it.operation = OP_REWIND;
      if ($urandom_range(4) != 0) it.step = 17'($urandom_range(0, trail_cnt));
    end else begin
      it.operation = OP_NOP;
    end
    return it;
  endfunction

  task automatic test_random_shape(logic [DIM_W-1:0] w, logic [DIM_W-1:0] d,
                                   logic [DIM_W-1:0] h, int gap, int stall, int count);
    reshape_grid(w, d, h);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        errs++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_data.status);
          errs++;
        end
        if (out_data.domain_bits !== exp_r.domain_bits) begin
          $error("domain_bits: expected %h, got %h", exp_r.domain_bits, out_data.domain_bits);
          errs++;
        end
        if (out_data.trail_length !== exp_r.trail_length) begin
          $error("trail_length: expected %0d, got %0d", exp_r.trail_length,
                 out_data.trail_length);
          errs++;
        end
      end
    end
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    errs = 0;
    send_gap_pct = 30;
    recv_stall_pct = 73;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    foreach (dom_s[i]) dom_s[i] = '0;
    foreach (rule_s[i]) rule_s[i] = '0;
    drop_queue();
    trail_cnt = 0;
    gw = DIM_MAX;
    gd = DIM_MAX;
    gh = DIM_MAX;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rule_load();
    test_directed();
    test_random_shape(4, 3, 2, 30, 73, 150);
    test_random_shape(0, 20, 1, 30, 73, 150);
    test_random_shape(1, 16, 1, 73, 30, 150);
    test_random_shape(1, 1, 16, 73, 30, 150);
    test_random_shape(3, 2, 5, 0, 0, 150);
    test_random_shape(2, 2, 2, 0, 0, 150);

    wait_idle();
    if (errs == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
